// ----- rtl/atct_pkg.sv -----
// Shared types, character constants and expansion tables of the terminal code translator.
// No dependencies; imported by every other file but atct_if and atct_checker.
package atct_pkg;

    localparam int ATCT_QUEUE_DEPTH = 4;

    // Most results one input byte may cause; longer expansions are cut off here
    localparam int MAX_RESULTS = 24;

    // Emulation modes as held in the mode register
    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_FF     = 3'd1,
        MODE_AVATAR = 3'd2,
        MODE_ANSI   = 3'd3,
        MODE_VT52   = 3'd4
    } mode_t;

    // Register indexes on the configuration port
    localparam logic REG_MODE       = 1'b0;
    localparam logic REG_CLEAR_ATTR = 1'b1;

    // Control and text characters
    localparam logic [7:0] CH_ATTR_CODE  = 8'h01;
    localparam logic [7:0] CH_BLINK_CODE = 8'h02;
    localparam logic [7:0] CH_BEL        = 8'h07;
    localparam logic [7:0] CH_BS         = 8'h08;
    localparam logic [7:0] CH_LF         = 8'h0a;
    localparam logic [7:0] CH_FF         = 8'h0c;
    localparam logic [7:0] CH_CR         = 8'h0d;
    localparam logic [7:0] CH_DLE        = 8'h10;
    localparam logic [7:0] CH_CTRL_V     = 8'h16;
    localparam logic [7:0] CH_CTRL_Y     = 8'h19;
    localparam logic [7:0] CH_ESC        = 8'h1b;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DEL        = 8'h7f;
    localparam logic [7:0] CH_LBRACKET   = 8'h5b;
    localparam logic [7:0] CH_SEMI       = 8'h3b;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_ONE        = 8'h31;
    localparam logic [7:0] CH_TWO        = 8'h32;
    localparam logic [7:0] CH_THREE      = 8'h33;
    localparam logic [7:0] CH_FOUR       = 8'h34;
    localparam logic [7:0] CH_FIVE       = 8'h35;
    localparam logic [7:0] CH_UPPER_E    = 8'h45;
    localparam logic [7:0] CH_UPPER_J    = 8'h4a;
    localparam logic [7:0] CH_LOWER_M    = 8'h6d;

    localparam logic [6:0] TIMES_MAX = 7'd127;

    // Kinds of byte sequence the back end can play out
    typedef enum logic [2:0] {
        PK_BYTE     = 3'd0,
        PK_CRLF     = 3'd1,
        PK_CLR      = 3'd2,
        PK_ESCE     = 3'd3,
        PK_BLINK    = 3'd4,
        PK_ATTR     = 3'd5,
        PK_CLR_ATTR = 3'd6,
        PK_REPEAT   = 3'd7
    } piece_kind_t;

    typedef struct packed {
        logic        valid;
        piece_kind_t kind;
        logic [7:0]  arg;
        logic [7:0]  cnt;
        logic        to_remote;
        logic        to_local;
    } piece_t;

    // One classified input: piece a first, then piece b, each with its own remote/local tags
    typedef struct packed {
        piece_t a;
        piece_t b;
    } cmd_t;

    typedef struct packed {
        logic [2:0] emulation_mode;
        logic [6:0] clear_attribute;
    } cfg_t;

    function automatic piece_t mk_piece(piece_kind_t kind, logic [7:0] arg,
                                        logic [7:0] cnt, logic r, logic l);
        piece_t p;
        p.valid     = 1'b1;
        p.kind      = kind;
        p.arg       = arg;
        p.cnt       = cnt;
        p.to_remote = r;
        p.to_local  = l;
        return p;
    endfunction

    // AVATAR colour index to ANSI colour digit
    function automatic logic [7:0] colour_digit(logic [2:0] idx);
        logic [7:0] d;
        case (idx)
            3'd0:    d = CH_ZERO;
            3'd1:    d = CH_FOUR;
            3'd2:    d = CH_TWO;
            3'd3:    d = 8'h36;
            3'd4:    d = CH_ONE;
            3'd5:    d = CH_FIVE;
            3'd6:    d = CH_THREE;
            default: d = 8'h37;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] attr_len(logic [6:0] a);
        return a[3] ? 5'd12 : 5'd10;
    endfunction

    // ESC [ 0 ; 4 B ; 3 F (;1) m
    function automatic logic [7:0] attr_byte(logic [6:0] a, logic [3:0] idx);
        logic [7:0] d;
        case (idx)
            4'd0:    d = CH_ESC;
            4'd1:    d = CH_LBRACKET;
            4'd2:    d = CH_ZERO;
            4'd3:    d = CH_SEMI;
            4'd4:    d = CH_FOUR;
            4'd5:    d = colour_digit(a[6:4]);
            4'd6:    d = CH_SEMI;
            4'd7:    d = CH_THREE;
            4'd8:    d = colour_digit(a[2:0]);
            4'd9:    d = a[3] ? CH_SEMI : CH_LOWER_M;
            4'd10:   d = CH_ONE;
            default: d = CH_LOWER_M;
        endcase
        return d;
    endfunction

    // ESC [ 2 J
    function automatic logic [7:0] clr_byte(logic [1:0] idx);
        logic [7:0] d;
        case (idx)
            2'd0:    d = CH_ESC;
            2'd1:    d = CH_LBRACKET;
            2'd2:    d = CH_TWO;
            default: d = CH_UPPER_J;
        endcase
        return d;
    endfunction

    // ESC [ 5 m
    function automatic logic [7:0] blink_byte(logic [1:0] idx);
        logic [7:0] d;
        case (idx)
            2'd0:    d = CH_ESC;
            2'd1:    d = CH_LBRACKET;
            2'd2:    d = CH_FIVE;
            default: d = CH_LOWER_M;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] piece_len(piece_kind_t kind, logic [7:0] arg);
        logic [4:0] n;
        case (kind)
            PK_CRLF:     n = 5'd2;
            PK_CLR:      n = 5'd4;
            PK_ESCE:     n = 5'd2;
            PK_BLINK:    n = 5'd4;
            PK_ATTR:     n = attr_len(arg[6:0]);
            PK_CLR_ATTR: n = 5'(attr_len(arg[6:0]) + 5'd4);
            default:     n = 5'd1;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] piece_byte(piece_kind_t kind, logic [7:0] arg,
                                              logic [3:0] step);
        logic [7:0] d;
        case (kind)
            PK_CRLF:     d = step[0] ? CH_LF : CH_CR;
            PK_CLR:      d = clr_byte(step[1:0]);
            PK_ESCE:     d = step[0] ? CH_UPPER_E : CH_ESC;
            PK_BLINK:    d = blink_byte(step[1:0]);
            PK_ATTR:     d = attr_byte(arg[6:0], step);
            PK_CLR_ATTR: d = (step < 4'd4) ? clr_byte(step[1:0])
                                           : attr_byte(arg[6:0], 4'(step - 4'd4));
            default:     d = arg;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/atct_if.sv -----
// Valid/ready channel interfaces for the text input and the code output.
// Depends on nothing; used by the translator modules.
interface atct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface atct_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       to_remote;
    logic       to_local;
    logic [6:0] times;
    logic       last;

    modport source (output valid, output out_byte, output to_remote, output to_local,
                    output times, output last, input ready);
    modport sink   (input valid, input out_byte, input to_remote, input to_local,
                    input times, input last, output ready);
endinterface

// ----- rtl/atct_front.sv -----
// Front end: accept text bytes, track the AVATAR decode phase, classify into commands.
// Depends on atct_pkg and atct_in_if.
module atct_front
    import atct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    atct_in_if.sink     text_ch,
    input  logic        queue_full,
    output logic        push,
    output cmd_t        push_cmd
);

    typedef enum logic [3:0] {
        PH_TEXT   = 4'b0001,
        PH_CTRLV  = 4'b0010,
        PH_ATTR   = 4'b0100,
        PH_REPEAT = 4'b1000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] rbyte_reg, rbyte_next;
    logic       rbv_reg, rbv_next;
    logic [2:0] mode;
    logic       avt;
    logic       accept;
    logic [7:0] c;
    logic [6:0] ca;
    cmd_t       cmd;

    assign text_ch.ready = !queue_full;
    assign accept        = text_ch.valid && text_ch.ready;
    assign c             = text_ch.in_byte;
    assign ca            = cfg.clear_attribute;
    assign mode          = (cfg.emulation_mode > MODE_VT52) ? MODE_NONE : cfg.emulation_mode;
    assign avt           = (mode == MODE_AVATAR);

    always_comb
    begin
        cmd        = '0;
        phase_next = phase_reg;
        rbyte_next = rbyte_reg;
        rbv_next   = rbv_reg;
        unique case (phase_reg)
            PH_TEXT:
            begin
                if (c == CH_LF)
                begin
                    cmd.a = mk_piece(PK_CRLF, '0, '0, 1'b1, 1'b1);
                end
                else if (c == CH_FF)
                begin
                    case (mode)
                        MODE_FF:
                        begin
                            cmd.a = mk_piece(PK_BYTE, CH_FF, '0, 1'b1, 1'b0);
                            cmd.b = mk_piece(PK_CLR, '0, '0, 1'b0, 1'b1);
                        end
                        MODE_AVATAR:
                        begin
                            cmd.a = mk_piece(PK_BYTE, CH_FF, '0, 1'b1, 1'b0);
                            cmd.b = mk_piece(PK_CLR_ATTR, {1'b0, ca}, '0, 1'b0, 1'b1);
                        end
                        MODE_ANSI:
                        begin
                            cmd.a = mk_piece(PK_CLR_ATTR, {1'b0, ca}, '0, 1'b1, 1'b0);
                            cmd.b = mk_piece(PK_CLR_ATTR, {1'b0, ca}, '0, 1'b0, 1'b1);
                        end
                        MODE_VT52:
                        begin
                            cmd.a = mk_piece(PK_ESCE, '0, '0, 1'b1, 1'b0);
                            cmd.b = mk_piece(PK_CLR_ATTR, {1'b0, ca}, '0, 1'b0, 1'b1);
                        end
                        default:
                        begin
                            cmd.a = mk_piece(PK_CRLF, '0, '0, 1'b1, 1'b1);
                        end
                    endcase
                end
                else if (c == CH_CTRL_V || c == CH_CTRL_Y)
                begin
                    if (avt)
                        cmd.a = mk_piece(PK_BYTE, c, '0, 1'b1, 1'b0);
                    phase_next = (c == CH_CTRL_V) ? PH_CTRLV : PH_REPEAT;
                end
                else if (c == CH_BEL || c == CH_BS || c == CH_CR
                         || (c >= CH_SPACE && c < CH_DEL))
                begin
                    cmd.a = mk_piece(PK_BYTE, c, '0, 1'b1, 1'b1);
                end
            end
            PH_CTRLV:
            begin
                phase_next = PH_TEXT;
                if (c == CH_ATTR_CODE)
                begin
                    if (avt)
                        cmd.a = mk_piece(PK_BYTE, c, '0, 1'b1, 1'b0);
                    phase_next = PH_ATTR;
                end
                else if (c == CH_BLINK_CODE)
                begin
                    if (avt)
                        cmd.a = mk_piece(PK_BYTE, c, '0, 1'b1, 1'b0);
                    else if (mode == MODE_ANSI)
                        cmd.a = mk_piece(PK_BLINK, '0, '0, 1'b1, 1'b0);
                    if (mode > MODE_FF)
                        cmd.b = mk_piece(PK_BLINK, '0, '0, 1'b0, 1'b1);
                end
            end
            PH_ATTR:
            begin
                // DLE as attribute is ignored; keep waiting
                if (c[6:0] != CH_DLE[6:0])
                begin
                    if (avt)
                        cmd.a = mk_piece(PK_BYTE, {1'b0, c[6:0]}, '0, 1'b1, 1'b0);
                    else if (mode == MODE_ANSI)
                        cmd.a = mk_piece(PK_ATTR, {1'b0, c[6:0]}, '0, 1'b1, 1'b0);
                    if (mode > MODE_FF)
                        cmd.b = mk_piece(PK_ATTR, {1'b0, c[6:0]}, '0, 1'b0, 1'b1);
                    phase_next = PH_TEXT;
                end
            end
            PH_REPEAT:
            begin
                if (avt)
                    cmd.a = mk_piece(PK_BYTE, c, '0, 1'b1, 1'b0);
                if (!rbv_reg)
                begin
                    rbyte_next = c;
                    rbv_next   = 1'b1;
                end
                else
                begin
                    // zero count repeats nothing
                    if (c != 8'd0)
                        cmd.b = mk_piece(PK_REPEAT, rbyte_reg, c, !avt, 1'b1);
                    phase_next = PH_TEXT;
                    rbyte_next = '0;
                    rbv_next   = 1'b0;
                end
            end
        endcase
    end

    assign push     = accept && (cmd.a.valid || cmd.b.valid);
    assign push_cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            rbyte_reg <= '0;
            rbv_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            rbyte_reg <= rbyte_next;
            rbv_reg   <= rbv_next;
        end
    end

endmodule

// ----- rtl/atct_queue.sv -----
// Short command queue between front and back end, registers with one read port.
// Depends on atct_pkg.
module atct_queue
    import atct_pkg::*;
#(
    parameter int DEPTH = ATCT_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic full,
    output logic empty,
    output cmd_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rptr_reg];

    function automatic logic [PW-1:0] wrap_inc(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : PW'(p + 1'b1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wrap_inc(wptr_reg);
            if (pop)
                rptr_reg <= wrap_inc(rptr_reg);
            if (push && !pop)
                count_reg <= CW'(count_reg + 1'b1);
            else if (pop && !push)
                count_reg <= CW'(count_reg - 1'b1);
        end
    end

endmodule

// ----- rtl/atct_back.sv -----
// Back end: play out commands as result bytes, one per unstalled cycle, into an output register.
// Depends on atct_pkg and atct_out_if.
module atct_back
    import atct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        queue_empty,
    input  cmd_t        head,
    output logic        pop,
    atct_out_if.source  code_ch
);

    logic       busy_reg;
    cmd_t       cmd_reg;
    logic       sel_reg;
    logic [3:0] step_reg;
    logic [7:0] rem_reg;
    logic [4:0] nres_reg;

    logic       ov_reg;
    logic [7:0] ob_reg;
    logic       or_reg, ol_reg, olast_reg;
    logic [6:0] ot_reg;

    piece_t     p;
    logic       adv;
    logic       piece_last, cmd_last;
    logic [7:0] item_byte;
    logic [6:0] item_times;

    assign p          = sel_reg ? cmd_reg.b : cmd_reg.a;
    assign adv        = busy_reg && (!ov_reg || code_ch.ready);
    assign item_byte  = piece_byte(p.kind, p.arg, step_reg);
    assign item_times = (p.kind == PK_REPEAT) ? (rem_reg[7] ? TIMES_MAX : rem_reg[6:0])
                                              : 7'd1;
    assign piece_last = (p.kind == PK_REPEAT) ? !rem_reg[7]
                                              : ({1'b0, step_reg} == 5'(piece_len(p.kind, p.arg) - 5'd1));
    // End the command on its final piece, or drop the rest once the result limit is hit
    assign cmd_last   = (piece_last && (sel_reg || !cmd_reg.b.valid))
                        || (nres_reg == 5'(MAX_RESULTS - 1));
    assign pop        = !queue_empty && (!busy_reg || (adv && cmd_last));

    // Sequencer over the pieces of the current command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
        end
        else if (adv && cmd_last)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= head;
            sel_reg  <= !head.a.valid;
            step_reg <= '0;
            rem_reg  <= head.a.valid ? head.a.cnt : head.b.cnt;
            nres_reg <= '0;
        end
        else if (adv)
        begin
            nres_reg <= 5'(nres_reg + 5'd1);
            if (!piece_last)
            begin
                step_reg <= 4'(step_reg + 4'd1);
                rem_reg  <= 8'(rem_reg - {1'b0, TIMES_MAX});
            end
            else if (!cmd_last)
            begin
                sel_reg  <= 1'b1;
                step_reg <= '0;
                rem_reg  <= cmd_reg.b.cnt;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= 1'b1;
        else if (code_ch.ready)
            ov_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ob_reg    <= item_byte;
            or_reg    <= p.to_remote;
            ol_reg    <= p.to_local;
            ot_reg    <= item_times;
            olast_reg <= cmd_last;
        end
    end

    assign code_ch.valid     = ov_reg;
    assign code_ch.out_byte  = ob_reg;
    assign code_ch.to_remote = or_reg;
    assign code_ch.to_local  = ol_reg;
    assign code_ch.times     = ot_reg;
    assign code_ch.last      = olast_reg;

endmodule

// ----- rtl/avatar_terminal_code_translator_unit.sv -----
// Top level of the AVATAR to terminal code translator: config registers, front, queue, back.
// Depends on atct_pkg, atct_if, atct_front, atct_queue and atct_back.
//
// Usage:
//   text_ch carries one outgoing text byte per transaction (valid/ready).
//   code_ch returns the translated bytes, one per transaction, each tagged
//   for the remote line and/or the local console, with a repeat count in
//   times and last set on the final byte an input byte caused. Inputs that
//   cause nothing (dropped bytes, code prefixes outside AVATAR mode) return no transaction.
//   The APB port holds emulation_mode at 0x0 and clear_attribute at 0x4;
//   write them only while no transaction is in flight.
// Timing:
//   The first result of an input passes the queue, the command register
//   and the output register. The back end emits one result per cycle while
//   the receiver takes them, so one input per cycle is sustained while each
//   input expands to at most one result; a longer expansion (up to 24
//   results, e.g. clear screen plus colour) holds the back end longer. The command
//   queue (QUEUE_DEPTH entries) keeps the input side moving during such bursts.
// Reset clears the decode phase, the held repeat byte, the queue and the
// output register; mode returns to none and the clear colour to cyan.
// A stalled receiver holds the output register, then fills the queue, and
// then drops text_ch.ready.
module avatar_terminal_code_translator_unit
    import atct_pkg::*;
#(
    parameter int QUEUE_DEPTH = ATCT_QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    atct_in_if.sink     text_ch,
    atct_out_if.source  code_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [2:0] mode_reg;
    logic [6:0] clr_attr_reg;
    cfg_t       cfg;
    logic       cfg_write;

    logic       push, pop, full, empty;
    cmd_t       push_cmd, head;

    // Register file; address bit 2 selects the register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_NONE;
            clr_attr_reg <= 7'd3;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_MODE)
                mode_reg <= pwdata[2:0];
            else
                clr_attr_reg <= pwdata[6:0];
        end
    end

    assign prdata = (paddr[2] == REG_CLEAR_ATTR) ? {25'd0, clr_attr_reg}
                                                 : {29'd0, mode_reg};

    assign cfg.emulation_mode  = mode_reg;
    assign cfg.clear_attribute = clr_attr_reg;

    // Classify each byte and advance the decode phase
    atct_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .text_ch    (text_ch),
        .queue_full (full),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    // Decouple classification from playout
    atct_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (full),
        .empty    (empty),
        .head     (head)
    );

    // Expand commands into result bytes
    atct_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (empty),
        .head        (head),
        .pop         (pop),
        .code_ch     (code_ch)
    );

endmodule

// ----- rtl/atct_checker.sv -----
// Port-level checks of the translator, bound to the top level.
// Depends on avatar_terminal_code_translator_unit.
module atct_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_remote,
    input logic       out_local,
    input logic [6:0] out_times,
    input logic       out_last,
    input logic       pready
);

    // Every result goes somewhere and is sent at least once
    a_result_sane: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_remote || out_local) && out_times != 7'd0))
        else $error("result with no destination or zero repeat count");

    // Nothing is presented right after reset release
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result valid right after reset");

    // A stalled result stays and holds its payload
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_byte)
            && $stable(out_times) && $stable(out_last)))
        else $error("stalled result changed");

    // The register port never waits
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind avatar_terminal_code_translator_unit atct_checker u_atct_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (code_ch.valid),
    .out_ready  (code_ch.ready),
    .out_byte   (code_ch.out_byte),
    .out_remote (code_ch.to_remote),
    .out_local  (code_ch.to_local),
    .out_times  (code_ch.times),
    .out_last   (code_ch.last),
    .pready     (pready)
);

// ----- tb/sv/atct_code_checker.sv -----
// Checker for the terminal code translator: watches the text, code and register ports,
// predicts the code transactions of every accepted text byte and compares them in order.
// Depends on atct_pkg and the channel interfaces of atct_if.
module atct_code_checker
    import atct_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    atct_in_if          text_ch,
    atct_out_if         code_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          failures,
    output int          pending
);

    localparam int         BURST_MAX        = 24;
    localparam int         REPORT_MAX       = 10;
    localparam logic [6:0] CLEAR_ATTR_RESET = 7'd3;
    // ANSI digit for each AVATAR colour index, index 0 in the top byte
    localparam logic [63:0] COLOUR_DIGITS   = "04261537";

    typedef enum logic [1:0] {
        DEC_TEXT,
        DEC_CTRL_V,
        DEC_ATTR,
        DEC_REPEAT
    } decode_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       to_remote;
        logic       to_local;
        logic [6:0] times;
        logic       last;
    } code_item_t;

    logic [2:0] mode_q;
    logic [6:0] clear_attr_q;
    decode_t    phase_q;
    logic [7:0] held_byte;
    logic       held_valid;
    code_item_t burst_q[$];
    code_item_t codes_due[$];
    int         errors;

    function automatic logic [7:0] ansi_colour(logic [2:0] idx);
        return COLOUR_DIGITS[63 - 8 * idx -: 8];
    endfunction

    // Drop anything past the burst limit of one input byte.
    function automatic void emit_run(logic [7:0] b, logic r, logic l, logic [6:0] t);
        code_item_t it;
        if (burst_q.size() >= BURST_MAX)
            return;
        it.out_byte  = b;
        it.to_remote = r;
        it.to_local  = l;
        it.times     = t;
        it.last      = 1'b0;
        burst_q.push_back(it);
    endfunction

    function automatic void emit(logic [7:0] b, logic r, logic l);
        emit_run(b, r, l, 7'd1);
    endfunction

    function automatic void emit_clear(logic r, logic l);
        emit(CH_ESC, r, l);
        emit(CH_LBRACKET, r, l);
        emit(CH_TWO, r, l);
        emit(CH_UPPER_J, r, l);
    endfunction

    function automatic void emit_blink(logic r, logic l);
        emit(CH_ESC, r, l);
        emit(CH_LBRACKET, r, l);
        emit(CH_FIVE, r, l);
        emit(CH_LOWER_M, r, l);
    endfunction

    // ESC [ 0 ; 4 bg ; 3 fg, bold suffix on bit 3, then m
    function automatic void emit_colour(logic [6:0] a, logic r, logic l);
        emit(CH_ESC, r, l);
        emit(CH_LBRACKET, r, l);
        emit(CH_ZERO, r, l);
        emit(CH_SEMI, r, l);
        emit(CH_FOUR, r, l);
        emit(ansi_colour(a[6:4]), r, l);
        emit(CH_SEMI, r, l);
        emit(CH_THREE, r, l);
        emit(ansi_colour(a[2:0]), r, l);
        if (a[3])
        begin
            emit(CH_SEMI, r, l);
            emit(CH_ONE, r, l);
        end
        emit(CH_LOWER_M, r, l);
    endfunction

    function automatic void emit_form_feed(logic [2:0] eff);
        case (eff)
            MODE_FF, MODE_AVATAR:
                emit(CH_FF, 1'b1, 1'b0);
            MODE_ANSI:
            begin
                emit_clear(1'b1, 1'b0);
                emit_colour(clear_attr_q, 1'b1, 1'b0);
            end
            MODE_VT52:
            begin
                emit(CH_ESC, 1'b1, 1'b0);
                emit(CH_UPPER_E, 1'b1, 1'b0);
            end
            default:
            begin
                emit(CH_CR, 1'b1, 1'b1);
                emit(CH_LF, 1'b1, 1'b1);
            end
        endcase
        if (eff != MODE_NONE)
        begin
            emit_clear(1'b0, 1'b1);
            if (eff > MODE_FF)
                emit_colour(clear_attr_q, 1'b0, 1'b1);
        end
    endfunction

    // Advance the decoder by one text byte and queue the codes it causes.
    function automatic void translate_byte(logic [7:0] c);
        logic [2:0] eff;
        logic       avt;
        logic [6:0] attr;
        int         left;
        int         run;
        code_item_t tail;
        eff = (mode_q > MODE_VT52) ? MODE_NONE : mode_q;
        avt = (eff == MODE_AVATAR);
        attr = c[6:0];
        burst_q.delete();
        case (phase_q)
            DEC_TEXT:
            begin
                if (c == CH_LF)
                begin
                    emit(CH_CR, 1'b1, 1'b1);
                    emit(CH_LF, 1'b1, 1'b1);
                end
                else if (c == CH_FF)
                    emit_form_feed(eff);
                else if (c == CH_CTRL_V)
                begin
                    if (avt)
                        emit(c, 1'b1, 1'b0);
                    phase_q = DEC_CTRL_V;
                end
                else if (c == CH_CTRL_Y)
                begin
                    if (avt)
                        emit(c, 1'b1, 1'b0);
                    phase_q = DEC_REPEAT;
                end
                else if (c == CH_BEL || c == CH_BS || c == CH_CR ||
                         (c >= CH_SPACE && c < CH_DEL))
                    emit(c, 1'b1, 1'b1);
            end
            DEC_CTRL_V:
            begin
                if (c == CH_ATTR_CODE)
                begin
                    if (avt)
                        emit(c, 1'b1, 1'b0);
                    phase_q = DEC_ATTR;
                end
                else
                begin
                    if (c == CH_BLINK_CODE)
                    begin
                        if (avt)
                            emit(c, 1'b1, 1'b0);
                        else if (eff == MODE_ANSI)
                            emit_blink(1'b1, 1'b0);
                        if (eff > MODE_FF)
                            emit_blink(1'b0, 1'b1);
                    end
                    phase_q = DEC_TEXT;
                end
            end
            DEC_ATTR:
            begin
                // a DLE attribute keeps the decoder waiting
                if (attr != CH_DLE[6:0])
                begin
                    if (avt)
                        emit({1'b0, attr}, 1'b1, 1'b0);
                    else if (eff == MODE_ANSI)
                        emit_colour(attr, 1'b1, 1'b0);
                    if (eff > MODE_FF)
                        emit_colour(attr, 1'b0, 1'b1);
                    phase_q = DEC_TEXT;
                end
            end
            default:
            begin
                if (avt)
                    emit(c, 1'b1, 1'b0);
                if (!held_valid)
                begin
                    held_byte  = c;
                    held_valid = 1'b1;
                end
                else
                begin
                    left = c;
                    while (left > 0)
                    begin
                        run = (left > TIMES_MAX) ? TIMES_MAX : left;
                        emit_run(held_byte, !avt, 1'b1, 7'(run));
                        left -= run;
                    end
                    phase_q    = DEC_TEXT;
                    held_byte  = 8'h00;
                    held_valid = 1'b0;
                end
            end
        endcase
        if (burst_q.size() > 0)
        begin
            tail = burst_q.pop_back();
            tail.last = 1'b1;
            burst_q.push_back(tail);
        end
        foreach (burst_q[i])
            codes_due.push_back(burst_q[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        code_item_t seen;
        code_item_t due;
        if (!rst_n)
        begin
            mode_q       = MODE_NONE;
            clear_attr_q = CLEAR_ATTR_RESET;
            phase_q      = DEC_TEXT;
            held_byte    = 8'h00;
            held_valid   = 1'b0;
            errors       = 0;
            codes_due.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            // compare delivered codes before taking new text, the order the block keeps
            if (code_ch.valid && code_ch.ready)
            begin
                seen.out_byte  = code_ch.out_byte;
                seen.to_remote = code_ch.to_remote;
                seen.to_local  = code_ch.to_local;
                seen.times     = code_ch.times;
                seen.last      = code_ch.last;
                if (codes_due.size() == 0)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("unexpected code: byte %02h remote %0b local %0b times %0d last %0b",
                                 seen.out_byte, seen.to_remote, seen.to_local, seen.times,
                                 seen.last);
                end
                else
                begin
                    due = codes_due.pop_front();
                    if (seen.out_byte !== due.out_byte || seen.to_remote !== due.to_remote ||
                        seen.to_local !== due.to_local || seen.times !== due.times ||
                        seen.last !== due.last)
                    begin
                        errors++;
                        if (errors <= REPORT_MAX)
                            $display("code mismatch at %0t: expected %02h r%0b l%0b x%0d last%0b, got %02h r%0b l%0b x%0d last%0b",
                                     $time, due.out_byte, due.to_remote, due.to_local,
                                     due.times, due.last, seen.out_byte, seen.to_remote,
                                     seen.to_local, seen.times, seen.last);
                    end
                end
            end
            if (text_ch.valid && text_ch.ready)
                translate_byte(text_ch.in_byte);
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == REG_CLEAR_ATTR)
                    clear_attr_q = pwdata[6:0];
                else
                    mode_q = pwdata[2:0];
            end
            failures <= errors;
            pending  <= codes_due.size();
        end
    end

endmodule

// ----- tb/sv/avatar_terminal_code_translator_unit_tb.sv -----
// Testbench top for the AVATAR terminal code translator: clock, reset, text stimulus,
// receiver stalls, register writes and the verdict.
// Depends on atct_pkg, atct_if, the translator RTL and atct_code_checker.
module avatar_terminal_code_translator_unit_tb
    import atct_pkg::*;
();

    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 12;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int ITEMS_PER_PHASE = 18;
    localparam int PHASES          = 10;
    localparam int RUN_LIMIT       = 3000000;

    // Mode codes the block does not know; they must act as no emulation.
    localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [2:0] MODE_SPARE_MID = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI  = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          failures;
    int          pending;

    // Set by the stimulus, cleared by the receiver once its long hold-off is over.
    logic hold_req = 1'b0;
    int   burst_left = 0;
    int   random_items = 0;

    // One setting per random phase; the hold-off phase runs with the longest expansions.
    logic [2:0] phase_modes [PHASES] = '{MODE_AVATAR, MODE_ANSI, MODE_NONE, MODE_FF,
                                         MODE_VT52, MODE_SPARE_LO, MODE_AVATAR,
                                         MODE_SPARE_HI, MODE_ANSI, MODE_SPARE_MID};

    // Field extremes, every control code, the dropped bytes, an ignored DLE attribute
    // with bit 7 set on the real one, an unknown code after ^V, a zero repeat count and
    // a repeat that splits into several transactions.
    logic [7:0] directed_bytes [24] = '{8'h00, 8'hff, CH_SPACE, 8'h7e, CH_DEL, CH_BEL,
                                        CH_BS, CH_CR, CH_LF, CH_FF,
                                        CH_CTRL_V, CH_ATTR_CODE, CH_DLE, 8'h8f,
                                        CH_CTRL_V, CH_BLINK_CODE, CH_CTRL_V, 8'h78,
                                        CH_CTRL_Y, 8'h41, 8'h00,
                                        CH_CTRL_Y, 8'h42, 8'hff};

    atct_in_if  text_ch ();
    atct_out_if code_ch ();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    avatar_terminal_code_translator_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_ch (text_ch),
        .code_ch (code_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    atct_code_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_ch  (text_ch),
        .code_ch  (code_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .pready   (pready),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .failures (failures),
        .pending  (pending)
    );

    // Offer one text byte and hold it until the block takes it. Every new burst may
    // start after a random gap; valid stays high between bytes of the same burst.
    task automatic offer(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                text_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        text_ch.valid   <= 1'b1;
        text_ch.in_byte <= b;
        do @(posedge clk); while (!text_ch.ready);
    endtask

    // Stop offering and wait until every predicted transaction has come back. Advance
    // past this edge first so the count includes the byte taken at it, then let the
    // block work off bytes that cause no transaction.
    task automatic drain();
        text_ch.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup then access phase; writes may follow back to back, so leave psel high.
    task automatic reg_write(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // Write both registers while idle, with junk above the register width.
    task automatic configure(input logic [2:0] mode, input logic [6:0] attr);
        logic [31:0] junk;
        drain();
        junk = $urandom();
        reg_write(REG_MODE, {junk[31:3], mode});
        junk = $urandom();
        reg_write(REG_CLEAR_ATTR, {junk[31:7], attr});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One random piece of text: mostly well-formed codes with random operands, some
    // raw noise that can break a sequence in the middle. Noise does not count as items.
    task automatic send_sequence();
        int         pick;
        int         sel;
        logic [7:0] arg;
        pick = $urandom_range(0, 99);
        if (pick < 30)
        begin
            offer(8'($urandom_range(32, 126)));
            random_items += 1;
        end
        else if (pick < 36)
        begin
            offer(CH_LF);
            random_items += 1;
        end
        else if (pick < 42)
        begin
            offer(CH_FF);
            random_items += 1;
        end
        else if (pick < 46)
        begin
            sel = $urandom_range(0, 2);
            offer((sel == 0) ? CH_BEL : (sel == 1) ? CH_BS : CH_CR);
            random_items += 1;
        end
        else if (pick < 60)
        begin
            offer(CH_CTRL_V);
            offer(CH_ATTR_CODE);
            random_items += 3;
            // a DLE attribute, with or without bit 7, is skipped by the block
            if ($urandom_range(0, 4) == 0)
            begin
                offer($urandom_range(0, 1) ? CH_DLE : (CH_DLE | 8'h80));
                random_items += 1;
            end
            offer(8'($urandom_range(0, 255)));
        end
        else if (pick < 68)
        begin
            offer(CH_CTRL_V);
            offer(CH_BLINK_CODE);
            random_items += 2;
        end
        else if (pick < 72)
        begin
            offer(CH_CTRL_V);
            offer(8'($urandom_range(0, 255)));
            random_items += 2;
        end
        else if (pick < 86)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
                arg = 8'h00;
            else if (sel < 7)
                arg = 8'($urandom_range(1, 12));
            else if (sel < 9)
                arg = 8'($urandom_range(128, 255));
            else
                arg = 8'($urandom_range(0, 255));
            offer(CH_CTRL_Y);
            offer(8'($urandom_range(0, 255)));
            offer(arg);
            random_items += 3;
        end
        else
            offer(8'($urandom_range(0, 255)));
    endtask

    // Receiver: switch between stall patterns after each random span, and hold off for
    // a long stretch when asked so the queue fills and the block drops text ready.
    initial
    begin : receiver
        int style;
        int span;
        code_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 60);
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                if (hold_req)
                begin
                    code_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_req <= 1'b0;
                end
                else
                begin
                    case (style)
                        0:       code_ch.ready <= 1'b1;
                        1:       code_ch.ready <= 1'($urandom_range(0, 1));
                        2:       code_ch.ready <= ((k % 3) == 0);
                        default: code_ch.ready <= ($urandom_range(0, 7) != 0);
                    endcase
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [6:0] attr;
        int         target;
        int         waited;
        rst_n           = 1'b0;
        text_ch.valid   = 1'b0;
        text_ch.in_byte = 8'h00;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'd0;
        pwdata          = 32'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under ANSI with the brightest clear colour: the form feed
        // overflows the burst limit there and must be cut short.
        configure(MODE_ANSI, 7'h7f);
        foreach (directed_bytes[i])
            offer(directed_bytes[i]);

        // Random phases, each under its own setting; every phase starts from an idle
        // block, so the sender pauses until all transactions are back.
        target = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            if ((p % 3) == 0)
                attr = 7'h00;
            else if ((p % 3) == 1)
                attr = 7'h7f;
            else
                attr = 7'($urandom_range(0, 127));
            configure(phase_modes[p], attr);
            if (p == 1)
                hold_req <= 1'b1;
            target += ITEMS_PER_PHASE;
            while (random_items < target)
                send_sequence();
        end

        // Wait for the last transactions, bounded, then give stray ones time to show.
        text_ch.valid <= 1'b0;
        @(posedge clk);
        for (waited = 0; waited < DRAIN_LIMIT && pending != 0; waited++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial
    begin : watchdog
        #(RUN_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule
